// ----- hw/rtl/lpfs_pkg.sv -----
// Package: frame geometry and header constants for the LED panel frame serializer.
`timescale 1ns / 1ps
`default_nettype none

package lpfs_pkg;

  // Columns per frame, left to right (range 2 to 168, even in normal use).
  localparam int FRAME_COLUMNS = 32;
  // Data bytes per frame: three bytes per column pair.
  localparam int DATA_BYTES    = (FRAME_COLUMNS * 3) / 2;

  localparam int COL_W         = 8;
  localparam int BYTE_W        = 8;
  localparam int PIX_W         = 12;
  // Most bytes one column can cause: three data bytes and four footer bytes.
  localparam int MAX_BYTES     = 7;
  localparam int CNT_W         = $clog2(MAX_BYTES + 1);

  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(FRAME_COLUMNS - 1);
  localparam logic [BYTE_W-1:0] HEADER_BYTE = BYTE_W'((DATA_BYTES + 2) % 256);
  localparam logic [BYTE_W-1:0] FOOTER_MARK = BYTE_W'(3);

endpackage

`default_nettype wire

// ----- hw/rtl/led_panel_frame_serializer.sv -----
// Top level: LED panel frame serializer, columns in, serial frame bytes out.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Slave channel (s_*): one 12-row panel column per transfer, left to right.
//   Master channel (m_*): the serial frame, one byte per transfer. tlast marks
//   the last byte caused by one column, tuser marks the final footer byte.
//   Config: cfg_we/cfg_wdata write the brightness register, used by the
//   next footer; write only while the block is idle.
// Timing
//   An accepted column is fully worked out in the accept cycle and lands in a
//   seven-byte output shift register; its first byte is offered in the next
//   cycle. That register drains one byte per cycle while m_tready is high,
//   and takes a column as its last waiting byte leaves, or whenever empty.
//   Bytes per column: none (inner even column, only its accept cycle),
//   1 (first column, header), 3 (odd column) or 7 (last column with footer).
//   The even column of a pair is taken as the last byte before it leaves;
//   the odd column is then taken while the output register sits empty, and
//   its three data bytes follow.
// Reset and stall
//   rst (synchronous) empties the output register and starts a new frame at
//   column 0 with a zeroed checksum and brightness. While m_tready is low the
//   current byte holds and s_tready stays low once a column's bytes are
//   waiting.

module led_panel_frame_serializer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Column in
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [15:0]                 s_tdata,   // [11:0] column_pixels
  // Serial bytes out
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // [7:0] serial_byte
  output logic                             m_tlast,   // run_last
  output logic                             m_tuser,   // [0] frame_end
  // Brightness register
  input  wire logic                        cfg_we,
  input  wire logic [7:0]                  cfg_wdata
);

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = v[k];
    return r;
  endfunction

  function automatic logic [3:0] rev4(input logic [3:0] v);
    logic [3:0] r;
    for (int k = 0; k < 4; k++) r[3-k] = v[k];
    return r;
  endfunction

  logic [lpfs_pkg::BYTE_W-1:0] brightness;
  logic [lpfs_pkg::COL_W-1:0]  column_count;
  logic [lpfs_pkg::PIX_W-1:0]  held_even_column;
  logic [lpfs_pkg::BYTE_W-1:0] running_sum;

  // Output shift register: res[0] is the byte on offer.
  logic [lpfs_pkg::BYTE_W-1:0] res [lpfs_pkg::MAX_BYTES];
  logic [lpfs_pkg::CNT_W-1:0]  res_count;
  logic                        end_flag;

  logic                        in_xfer, out_xfer;
  logic [lpfs_pkg::PIX_W-1:0]  col;
  logic                        first_col, odd_col, last_col;
  logic [lpfs_pkg::BYTE_W-1:0] byte_a, byte_b, byte_c;
  logic [lpfs_pkg::BYTE_W-1:0] sum_base, running_sum_next;
  logic [lpfs_pkg::BYTE_W-1:0] new_bytes [lpfs_pkg::MAX_BYTES];
  logic [lpfs_pkg::CNT_W-1:0]  new_count;
  logic                        new_end;

  assign m_tvalid = (res_count != '0);
  assign m_tdata  = res[0];
  assign m_tlast  = (res_count == lpfs_pkg::CNT_W'(1));
  assign m_tuser  = end_flag && m_tlast;
  // Take a column when nothing waits or the final waiting byte leaves now.
  assign s_tready = (res_count == '0) || (m_tlast && m_tready);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  assign col       = s_tdata[lpfs_pkg::PIX_W-1:0];
  assign first_col = (column_count == '0);
  assign odd_col   = column_count[0];
  assign last_col  = (column_count >= lpfs_pkg::LAST_COL);

  // Column pair packing: even rows 0..7 reversed, both upper nibbles reversed, odd rows 0..7 reversed.
  assign byte_a = rev8(held_even_column[7:0]);
  assign byte_b = {rev4(held_even_column[11:8]), rev4(col[11:8])};
  assign byte_c = rev8(col[7:0]);

  assign sum_base         = first_col ? lpfs_pkg::HEADER_BYTE : running_sum;
  assign running_sum_next = odd_col ? sum_base + byte_a + byte_b + byte_c : sum_base;

  always_comb begin
    for (int i = 0; i < lpfs_pkg::MAX_BYTES; i++) new_bytes[i] = '0;
    new_count = '0;
    new_end   = 1'b0;
    if (first_col) begin
      new_bytes[0] = lpfs_pkg::HEADER_BYTE;
      new_count    = lpfs_pkg::CNT_W'(1);
    end else if (odd_col) begin
      new_bytes[0] = byte_a;
      new_bytes[1] = byte_b;
      new_bytes[2] = byte_c;
      new_count    = lpfs_pkg::CNT_W'(3);
      if (last_col) begin
        new_bytes[3] = running_sum_next;
        new_bytes[4] = lpfs_pkg::FOOTER_MARK;
        new_bytes[5] = brightness;
        new_bytes[6] = brightness + lpfs_pkg::FOOTER_MARK;
        new_count    = lpfs_pkg::CNT_W'(7);
        new_end      = 1'b1;
      end
    end
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness       <= '0;
      column_count     <= '0;
      held_even_column <= '0;
      running_sum      <= '0;
      res_count        <= '0;
      end_flag         <= 1'b0;
    end else begin
      if (cfg_we) begin
        brightness <= cfg_wdata;
      end
      if (in_xfer) begin
        column_count <= last_col ? '0 : column_count + lpfs_pkg::COL_W'(1);
        if (!odd_col) begin
          held_even_column <= col;
        end
        running_sum <= running_sum_next;
        res_count   <= new_count;
        end_flag    <= new_end;
      end else if (out_xfer) begin
        res_count <= res_count - lpfs_pkg::CNT_W'(1);
      end
    end
  end

  // Byte payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < lpfs_pkg::MAX_BYTES; i++) res[i] <= new_bytes[i];
    end else if (out_xfer) begin
      for (int i = 0; i < lpfs_pkg::MAX_BYTES - 1; i++) res[i] <= res[i+1];
      res[lpfs_pkg::MAX_BYTES-1] <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lpfs_checker.sv -----
// Checker: port-level assertions for the LED panel frame serializer, with bind.
`timescale 1ns / 1ps
`default_nettype none

module lpfs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // Output empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Frame end only ever sits on the last byte of a column.
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end without run last");

  // A new column is taken only when the waiting bytes are gone or going.
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || (m_tlast && m_tready)))
    else $error("input ready while bytes still wait");

  // Stalled byte holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind led_panel_frame_serializer lpfs_checker u_lpfs_checker (.*);

`default_nettype wire
